// ===== hw/rtl/irpfd_pkg.sv =====
// Package: item types, frame state record and codes for the IR pulse frame decoder.
`default_nettype none

package irpfd_pkg;

  // Field widths
  localparam int unsigned US_W    = 20;
  localparam int unsigned CMD_W   = 8;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned LED_W   = 3;
  localparam int unsigned REG_IDX_W = 3;

  // Frame layout
  localparam int unsigned FRAME_EDGES_DEF = 50;
  localparam int unsigned CMD_FIRST_EDGE  = 17;

  // Register reset values
  localparam logic [US_W-1:0] LEADER_MIN_RST  = 20'd1000;
  localparam logic [US_W-1:0] LEADER_MAX_RST  = 20'd16000;
  localparam logic [US_W-1:0] ONE_BIT_MIN_RST = 20'd2000;
  localparam logic [US_W-1:0] ONE_BIT_MAX_RST = 20'd2400;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_LEADER_MIN  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LEADER_MAX  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ONE_BIT_MIN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ONE_BIT_MAX = 3'd3;

  // Opcodes
  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALL_OFF  = 8'd2;
  localparam logic [CMD_W-1:0] CMD_ALL_ON   = 8'd3;
  localparam logic [CMD_W-1:0] CMD_RED_ON   = 8'd4;
  localparam logic [CMD_W-1:0] CMD_GREEN_ON = 8'd5;
  localparam logic [CMD_W-1:0] CMD_BLUE_ON  = 8'd6;

  typedef struct packed {
    logic            opcode;
    logic [US_W-1:0] elapsed_us;
  } ev_item_t;

  typedef struct packed {
    logic             frame_valid;
    logic [CMD_W-1:0] command;
    logic             red_on;
    logic             green_on;
    logic             blue_on;
  } res_item_t;

  // One memory word: the whole decoder state
  typedef struct packed {
    logic             frame_started;
    logic [IDX_W-1:0] edge_index;
    logic [US_W-1:0]  leader_interval;
    logic [CMD_W-1:0] command_bits;
    logic [LED_W-1:0] led_bits;
  } frame_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ir_pulse_frame_decoder_top.sv =====
// IR pulse frame decoder: state memory with read-modify-write and a result register.
// A timeout item passes through the work stage and its result is then registered in the result register.
// Throughput: one item per cycle while no timeout is held; the state word sits in a one-entry memory
// read at accept and written back from the work stage, with forwarding of that write.
// A timeout waits in the work stage only while the result register is full and stalled.
// Reset (rst, synchronous): state reads as zero, registers take defaults, no item in flight.
`default_nettype none

module ir_pulse_frame_decoder_top #(
  parameter int unsigned FRAME_EDGES = irpfd_pkg::FRAME_EDGES_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   ev_valid,
  output logic                                  ev_stall,
  input  irpfd_pkg::ev_item_t                   ev_item,
  output logic                                  res_valid,
  input  wire                                   res_stall,
  output irpfd_pkg::res_item_t                  res_item,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [irpfd_pkg::REG_IDX_W-1:0]       cfg_index,
  input  wire  [irpfd_pkg::US_W-1:0]            cfg_data
);
  import irpfd_pkg::*;

  // Configuration registers
  logic [US_W-1:0] leader_min;
  logic [US_W-1:0] leader_max;
  logic [US_W-1:0] one_bit_min;
  logic [US_W-1:0] one_bit_max;

  // State memory and its read port
  frame_state_t mem [0:0];
  logic         mem_ok;
  frame_state_t rd_q;
  logic         rd_ok_q;
  frame_state_t fwd_q;
  logic         fwd_sel;

  // Work stage
  logic         s1_valid;
  ev_item_t     s1_item;
  logic         s1_hold;
  logic         s1_adv;
  logic         ev_accept;

  frame_state_t st_cur;
  frame_state_t st_next;
  logic         leader_ok;
  logic         bit_one;
  logic [IDX_W-1:0] bit_off;
  logic [CMD_W-1:0] cmd;
  res_item_t    res_next;

  assign cfg_ready = 1'b1;

  // Hold a timeout while the result register cannot take it
  assign s1_hold   = s1_valid && (s1_item.opcode == OP_TIMEOUT) && res_valid && res_stall;
  assign s1_adv    = s1_valid && !s1_hold;
  assign ev_stall  = s1_hold;
  assign ev_accept = ev_valid && !ev_stall;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      leader_min  <= LEADER_MIN_RST;
      leader_max  <= LEADER_MAX_RST;
      one_bit_min <= ONE_BIT_MIN_RST;
      one_bit_max <= ONE_BIT_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEADER_MIN:  leader_min  <= cfg_data;
        REG_LEADER_MAX:  leader_max  <= cfg_data;
        REG_ONE_BIT_MIN: one_bit_min <= cfg_data;
        REG_ONE_BIT_MAX: one_bit_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the work stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_hold) begin
      s1_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_accept) begin
      s1_item <= ev_item;
    end
  end

  // Read the state word at accept; note a write-back at the same edge
  always_ff @(posedge clk) begin
    if (ev_accept) begin
      rd_q    <= mem[0];
      rd_ok_q <= mem_ok;
      fwd_sel <= s1_adv;
    end
  end

  // Write back the updated state word
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mem[0] <= st_next;
      fwd_q  <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_ok <= 1'b0;
    end else if (s1_adv) begin
      mem_ok <= 1'b1;
    end
  end

  // Pick forwarded, stored or reset state
  always_comb begin
    if (fwd_sel) begin
      st_cur = fwd_q;
    end else if (rd_ok_q) begin
      st_cur = rd_q;
    end else begin
      st_cur = '0;
    end
  end

  // Modify the state word
  always_comb begin
    st_next   = st_cur;
    leader_ok = (st_cur.leader_interval >= leader_min) &&
                (st_cur.leader_interval <= leader_max);
    bit_one   = (s1_item.elapsed_us >= one_bit_min) &&
                (s1_item.elapsed_us <= one_bit_max);
    bit_off   = st_cur.edge_index - IDX_W'(CMD_FIRST_EDGE);
    cmd       = leader_ok ? st_cur.command_bits : '0;
    res_next  = '0;
    if (s1_item.opcode == OP_EDGE) begin
      if (!st_cur.frame_started) begin
        st_next.frame_started = 1'b1;
      end else if (st_cur.edge_index < IDX_W'(FRAME_EDGES)) begin
        if (st_cur.edge_index == '0) begin
          st_next.leader_interval = s1_item.elapsed_us;
        end
        if ((st_cur.edge_index >= IDX_W'(CMD_FIRST_EDGE)) &&
            (st_cur.edge_index < IDX_W'(CMD_FIRST_EDGE + CMD_W))) begin
          st_next.command_bits[bit_off[2:0]] = bit_one;
        end
        st_next.edge_index = st_cur.edge_index + 1'b1;
      end
    end else begin
      if (leader_ok) begin
        case (cmd)
          CMD_ALL_ON:   st_next.led_bits = '1;
          CMD_ALL_OFF:  st_next.led_bits = '0;
          CMD_RED_ON:   st_next.led_bits[0] = 1'b1;
          CMD_GREEN_ON: st_next.led_bits[1] = 1'b1;
          CMD_BLUE_ON:  st_next.led_bits[2] = 1'b1;
          default: ;
        endcase
      end
      res_next.frame_valid = leader_ok;
      res_next.command     = cmd;
      res_next.red_on      = st_next.led_bits[0];
      res_next.green_on    = st_next.led_bits[1];
      res_next.blue_on     = st_next.led_bits[2];
      // Clear the frame, keep the LED lines
      st_next.frame_started   = 1'b0;
      st_next.edge_index      = '0;
      st_next.leader_interval = '0;
      st_next.command_bits    = '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && (s1_item.opcode == OP_TIMEOUT)) begin
      res_valid <= 1'b1;
      res_item  <= res_next;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Checks
  a_hold_keeps_item : assert property (@(posedge clk) disable iff (rst)
    s1_hold |=> s1_valid && (s1_item.opcode == OP_TIMEOUT))
    else $error("held timeout item lost from work stage");

  a_invalid_zero_cmd : assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.frame_valid |-> res_item.command == '0)
    else $error("invalid frame carries a nonzero command");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !res_valid && !s1_valid && !mem_ok)
    else $error("pipeline not empty after reset");

  a_fwd_after_write : assert property (@(posedge clk) disable iff (rst)
    ev_accept && s1_adv |=> fwd_sel && (fwd_q == $past(st_next)))
    else $error("write-back not forwarded to the next item");

endmodule

`default_nettype wire
